[hw/rtl/i2cw_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master write engine: shared package
// Item types, command classification, bus phase codes and configuration
// register indexes used across the engine's modules.
// ----------------------------------------------------------------------------
package i2cw_pkg;

  // Input item as seen on the in_ channel.
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       sda_sample;
  } in_item_t;

  // Result item as driven on the out_ channel.
  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic sda_output_enable;
    logic byte_wanted;
    logic busy_res;
    logic done_res;
    logic status;
  } out_item_t;

  // Operation codes carried by an input item.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_OFFER = 1'b1;

  // Classified command kinds handed from the front end to the engine.
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_OFFER = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       sda_sample;
  } cmd_t;

  // Queue status seen by the front end and the engine.
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  // Bus phases of a write transaction.
  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST1  = 5'd1,
    PH_ST2  = 5'd2,
    PH_ST3  = 5'd3,
    PH_BLO  = 5'd4,
    PH_BHI  = 5'd5,
    PH_AKLO = 5'd6,
    PH_AKHI = 5'd7,
    PH_WAIT = 5'd8,
    PH_SP1  = 5'd9,
    PH_SP2  = 5'd10,
    PH_SP3  = 5'd11,
    PH_SP4  = 5'd12
  } phase_t;

  // Configuration register indexes.
  localparam logic CFG_DEV_ADDR    = 1'b0;
  localparam logic CFG_PHASE_TICKS = 1'b1;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Byte framing constants.
  localparam logic [7:0] MSB_MASK      = 8'h80;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [TIMER_W-1:0] DEFAULT_PHASE_TICKS = 16'd10;

endpackage

[hw/rtl/i2cw_front.sv]
// ----------------------------------------------------------------------------
// I2C master write engine: front end
// Accepts input items while the command queue has room and classifies each
// one into a tick command or a byte offer command.
// ----------------------------------------------------------------------------
module i2cw_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  i2cw_pkg::in_item_t in_data,
  input  i2cw_pkg::q_stat_t  q_stat,
  output logic               push_valid,
  output i2cw_pkg::cmd_t     push_cmd
);
  import i2cw_pkg::*;

  // An item is taken whenever the queue has a free slot.
  assign in_ready   = !q_stat.full;
  assign push_valid = in_valid && !q_stat.full;

  // Classify the item; fields not used by a tick are cleared.
  always_comb begin
    push_cmd = '0;
    if (in_data.operation == OP_OFFER) begin
      push_cmd.kind      = CMD_OFFER;
      push_cmd.data_byte = in_data.data_byte;
      push_cmd.last_byte = in_data.last_byte;
    end else begin
      push_cmd.kind       = CMD_TICK;
      push_cmd.sda_sample = in_data.sda_sample;
    end
  end

endmodule

[hw/rtl/i2cw_queue.sv]
// ----------------------------------------------------------------------------
// I2C master write engine: command queue
// Two-entry FIFO that decouples the front end from the bus engine.
// ----------------------------------------------------------------------------
module i2cw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  i2cw_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output i2cw_pkg::q_stat_t q_stat,
  output i2cw_pkg::cmd_t    q_cmd
);
  import i2cw_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  // Status toward both neighbors.
  assign q_stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_stat.valid = (count_r != '0);
  assign q_cmd        = slot_r[rd_ptr_r];

  assign do_push = push_valid && !q_stat.full;
  assign do_pop  = pop && q_stat.valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/i2cw_back.sv]
// ----------------------------------------------------------------------------
// I2C master write engine: bus engine
// Executes one queued command per cycle on the bus phase machine while the
// output is not stalled and registers the line levels and status as one item.
// ----------------------------------------------------------------------------
module i2cw_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  i2cw_pkg::q_stat_t                   q_stat,
  input  i2cw_pkg::cmd_t                      q_cmd,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output i2cw_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_index,
  input  logic [i2cw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import i2cw_pkg::*;

  // Configuration registers.
  logic [7:0]         dev_addr_r;
  logic [TIMER_W-1:0] phase_ticks_r;

  // Engine state.
  phase_t             phase_r, phase_nxt;
  logic [3:0]         bit_count_r, bit_count_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic               final_r, final_nxt;
  logic               pending_r, pending_nxt;
  logic               error_r, error_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic [7:0]         held_byte_r, held_byte_nxt;
  logic               held_last_r, held_last_nxt;
  logic               shift_last_r, shift_last_nxt;

  // Result register.
  logic               out_valid_r;
  out_item_t          out_data_r;
  out_item_t          res;
  logic               done;

  // Decode helpers.
  logic               fire, is_offer, is_tick;
  logic               wanted_cur, open_txn, accept_byte, load_wait, adv_fire;
  logic [TIMER_W-1:0] need;
  logic [TIMER_W:0]   tick_sum;
  logic               adv;
  logic [3:0]         bc_inc;
  logic               byte_end;

  // Configuration writes; the port never stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= '0;
      phase_ticks_r <= DEFAULT_PHASE_TICKS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEV_ADDR:    dev_addr_r    <= cfg_data[7:0];
        CFG_PHASE_TICKS: phase_ticks_r <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // A command executes when the result register is free or being emptied.
  assign fire = q_stat.valid && (!out_valid_r || out_ready);
  assign pop  = fire;

  assign is_offer   = (q_cmd.kind == CMD_OFFER);
  assign is_tick    = (q_cmd.kind == CMD_TICK);
  assign wanted_cur = !pending_r && !((phase_r != PH_IDLE) && final_r);

  assign accept_byte = fire && is_offer && wanted_cur;
  assign open_txn    = accept_byte && (phase_r == PH_IDLE);
  assign load_wait   = fire && is_tick && (phase_r == PH_WAIT) && pending_r;

  // Phase timer compare; zero ticks behaves as one.
  assign need     = (phase_ticks_r == '0) ? TIMER_W'(1) : phase_ticks_r;
  assign tick_sum = {1'b0, timer_r} + (TIMER_W+1)'(1);
  assign adv      = (tick_sum >= {1'b0, need});
  assign adv_fire = fire && is_tick && (phase_r != PH_IDLE) && (phase_r != PH_WAIT) && adv;

  assign bc_inc   = bit_count_r + 4'd1;
  assign byte_end = (bc_inc >= BITS_PER_BYTE);

  // Next bus phase.
  always_comb begin
    phase_nxt = phase_r;
    if (open_txn) begin
      phase_nxt = PH_ST1;
    end else if (load_wait) begin
      phase_nxt = PH_BLO;
    end else if (adv_fire) begin
      unique case (phase_r)
        PH_ST1:  phase_nxt = PH_ST2;
        PH_ST2:  phase_nxt = PH_ST3;
        PH_ST3:  phase_nxt = PH_BLO;
        PH_BLO:  phase_nxt = PH_BHI;
        PH_BHI:  phase_nxt = byte_end ? PH_AKLO : PH_BLO;
        PH_AKLO: phase_nxt = PH_AKHI;
        PH_AKHI: begin
          if (q_cmd.sda_sample || shift_last_r) begin
            phase_nxt = PH_SP1;
          end else if (pending_r) begin
            phase_nxt = PH_BLO;
          end else begin
            phase_nxt = PH_WAIT;
          end
        end
        PH_SP1:  phase_nxt = PH_SP2;
        PH_SP2:  phase_nxt = PH_SP3;
        PH_SP3:  phase_nxt = PH_SP4;
        PH_SP4:  phase_nxt = PH_IDLE;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Datapath and line levels that go with each phase step.
  always_comb begin
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    timer_nxt      = timer_r;
    final_nxt      = final_r;
    pending_nxt    = pending_r;
    error_nxt      = error_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    held_byte_nxt  = held_byte_r;
    held_last_nxt  = held_last_r;
    shift_last_nxt = shift_last_r;
    done           = 1'b0;

    if (accept_byte) begin
      // Hold the offered byte; opening a transaction loads the address.
      held_byte_nxt = q_cmd.data_byte;
      held_last_nxt = q_cmd.last_byte;
      pending_nxt   = 1'b1;
      if (q_cmd.last_byte) begin
        final_nxt = 1'b1;
      end
      if (open_txn) begin
        error_nxt      = 1'b0;
        final_nxt      = q_cmd.last_byte;
        shift_nxt      = dev_addr_r;
        shift_last_nxt = 1'b0;
        bit_count_nxt  = '0;
        sda_nxt        = 1'b1;
        timer_nxt      = '0;
      end
    end else if (load_wait) begin
      shift_nxt      = held_byte_r;
      shift_last_nxt = held_last_r;
      pending_nxt    = 1'b0;
      bit_count_nxt  = '0;
      scl_nxt        = 1'b0;
      sda_nxt        = ((held_byte_r & MSB_MASK) != '0);
      timer_nxt      = '0;
    end else if (adv_fire) begin
      timer_nxt = '0;
      unique case (phase_r)
        PH_ST1: scl_nxt = 1'b1;
        PH_ST2: sda_nxt = 1'b0;
        PH_ST3: begin
          bit_count_nxt = '0;
          scl_nxt       = 1'b0;
          sda_nxt       = ((shift_r & MSB_MASK) != '0);
        end
        PH_BLO: scl_nxt = 1'b1;
        PH_BHI: begin
          // Shift out the next bit unless the byte is complete.
          scl_nxt       = 1'b0;
          bit_count_nxt = bc_inc;
          shift_nxt     = {shift_r[6:0], 1'b0};
          if (!byte_end) begin
            sda_nxt = shift_r[6];
          end
        end
        PH_AKLO: scl_nxt = 1'b1;
        PH_AKHI: begin
          // Acknowledge sample: abort on a high level, else continue.
          scl_nxt = 1'b0;
          if (q_cmd.sda_sample) begin
            error_nxt   = 1'b1;
            pending_nxt = 1'b0;
          end else if (!shift_last_r && pending_r) begin
            shift_nxt      = held_byte_r;
            shift_last_nxt = held_last_r;
            pending_nxt    = 1'b0;
            bit_count_nxt  = '0;
            sda_nxt        = ((held_byte_r & MSB_MASK) != '0);
          end
        end
        PH_SP1: sda_nxt = 1'b0;
        PH_SP2: scl_nxt = 1'b1;
        PH_SP3: sda_nxt = 1'b1;
        PH_SP4: begin
          final_nxt      = 1'b0;
          shift_last_nxt = 1'b0;
          done           = 1'b1;
        end
        default: ;
      endcase
    end else if (fire && is_tick && (phase_r != PH_IDLE) && (phase_r != PH_WAIT)) begin
      timer_nxt = tick_sum[TIMER_W-1:0];
    end
  end

  // Result item built from the state after the step.
  always_comb begin
    res.scl_level         = scl_nxt;
    res.sda_level         = sda_nxt;
    res.sda_output_enable = !((phase_nxt == PH_AKLO) || (phase_nxt == PH_AKHI) ||
                              (phase_nxt == PH_WAIT));
    res.byte_wanted       = !pending_nxt && !((phase_nxt != PH_IDLE) && final_nxt);
    res.busy_res          = (phase_nxt != PH_IDLE);
    res.done_res          = done;
    res.status            = error_nxt;
  end

  // Engine state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_count_r  <= '0;
      shift_r      <= '0;
      timer_r      <= '0;
      final_r      <= 1'b0;
      pending_r    <= 1'b0;
      error_r      <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      shift_last_r <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      timer_r      <= timer_nxt;
      final_r      <= final_nxt;
      pending_r    <= pending_nxt;
      error_r      <= error_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      shift_last_r <= shift_last_nxt;
    end
  end

  // Held byte is payload and needs no reset.
  always_ff @(posedge clk) begin
    if (fire) begin
      held_byte_r <= held_byte_nxt;
      held_last_r <= held_last_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/i2c_master_write_engine_core.sv]
// ----------------------------------------------------------------------------
// I2C master write engine
// Bus-level I2C master for write-only transactions. Each input item is
// either a time tick carrying the sampled SDA level or a data byte offer;
// each item gives exactly one result item with the driven SCL/SDA levels,
// the SDA output enable and the transaction status.
//
// Channels: in_ (valid/ready, in_item_t), out_ (valid/ready, out_item_t)
// and cfg_ (valid/ready write: index 0 = device write address, index 1 =
// ticks per bus phase). cfg_ready is always high; write only while idle.
// A result passes through the command queue and the output register.
// Throughput: one item per cycle while the receiver takes results, as the
// bus phase machine in the engine takes one step per item.
// A two-entry command queue sits between the input front end and the
// engine, and the result is held in an output register, so a stalled
// receiver first fills the output register and then the queue before
// in_ready drops. Synchronous reset puts the bus lines high, the engine
// idle, the queue empty and the registers at their default values.
// ----------------------------------------------------------------------------
module i2c_master_write_engine_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  i2cw_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output i2cw_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [i2cw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import i2cw_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    q_cmd;
  logic    push_valid;
  logic    pop;

  // Register writes are never stalled.
  assign cfg_ready = 1'b1;

  i2cw_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  i2cw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .q_stat     (q_stat),
    .q_cmd      (q_cmd)
  );

  i2cw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[hw/rtl/i2cw_checker.sv]
// ----------------------------------------------------------------------------
// I2C master write engine: port checker
// Watches the top level's ports for result channel holding and for bus
// line and status combinations the engine must never report.
// ----------------------------------------------------------------------------
module i2cw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input i2cw_pkg::out_item_t             out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Outside a transaction both lines are driven high.
  a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |->
      out_data.scl_level && out_data.sda_level &&
      out_data.sda_output_enable)
    else $error("idle result with bus not released high");

  // The end of a transaction is reported only once it is no longer busy.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while busy");

  // SDA is released only inside a transaction.
  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sda_output_enable |-> out_data.busy_res)
    else $error("SDA released while idle");

endmodule

bind i2c_master_write_engine_core i2cw_checker u_i2cw_checker (.*);

[tb/tb_i2c_master_write_engine_core.sv]
// ----------------------------------------------------------------------------
// Testbench for the I2C master write engine core
// Drives tick and byte-offer items through the valid/ready input channel and
// checks every result item against a cycle-free model of the bus phase
// machine. Register settings change between runs of stimulus, the receiver
// stalls at random and once for a long stretch, and a watchdog catches hangs.
// ----------------------------------------------------------------------------
module tb_i2c_master_write_engine_core;
  import i2cw_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 1000;
  localparam int unsigned HOLD_CYCLES     = 40;
  localparam int unsigned HOLD_AT_RESULT  = 120;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned CALM_FROM       = 350;
  localparam int unsigned CALM_TO         = 480;

  // Mirror of the engine's architectural state.
  typedef struct packed {
    phase_t     ph;
    logic [3:0] bits;
    logic [7:0] shreg;
    logic [15:0] timer;
    logic       final_seen;
    logic       pending;
    logic       err;
    logic       scl;
    logic       sda;
    logic [7:0] held;
    logic       held_last;
    logic       shift_last;
    logic       done;
  } bus_model_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = CFG_DEV_ADDR;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Items waiting to be driven and bus levels waiting to be seen.
  in_item_t   pending_items[$];
  out_item_t  expected_bus[$];

  // One model follows the accepted items, the other the planned ones.
  bus_model_t  checked_bus;
  bus_model_t  planned_bus;
  logic [7:0]  checked_addr;
  logic [7:0]  planned_addr;
  logic [15:0] checked_ticks;
  logic [15:0] planned_ticks;

  logic        in_fire      = 1'b0;
  logic        hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned items_in     = 0;
  int unsigned results_out  = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  always #4 clk = ~clk;

  i2c_master_write_engine_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic bus_model_t idle_bus();
    bus_model_t s;
    s     = '0;
    s.ph  = PH_IDLE;
    s.scl = 1'b1;
    s.sda = 1'b1;
    return s;
  endfunction

  // A byte offer is taken unless one is already held or the last byte is in.
  function automatic logic offer_ok(bus_model_t s);
    return !s.pending && !(s.ph != PH_IDLE && s.final_seen);
  endfunction

  // Move the held byte into the shifter and start its first bit.
  function automatic bus_model_t load_byte(bus_model_t s);
    bus_model_t n;
    n            = s;
    n.shreg      = s.held;
    n.shift_last = s.held_last;
    n.pending    = 1'b0;
    n.bits       = '0;
    n.scl        = 1'b0;
    n.sda        = s.held[7];
    n.ph         = PH_BLO;
    n.timer      = '0;
    return n;
  endfunction

  function automatic in_item_t make_item(logic op, logic [7:0] data, logic last,
                                         logic sda_in);
    in_item_t it;
    it.operation  = op;
    it.data_byte  = data;
    it.last_byte  = last;
    it.sda_sample = sda_in;
    return it;
  endfunction

  // Next engine state after one input item.
  function automatic bus_model_t engine_step(bus_model_t s, logic [7:0] dev_addr,
                                             logic [15:0] ticks, in_item_t it);
    bus_model_t  n;
    logic [16:0] need;
    logic [16:0] t;
    n      = s;
    n.done = 1'b0;
    need   = (ticks == '0) ? 17'd1 : {1'b0, ticks};
    t      = {1'b0, s.timer} + 17'd1;
    if (it.operation == OP_OFFER) begin
      if (offer_ok(s)) begin
        n.held      = it.data_byte;
        n.held_last = it.last_byte;
        n.pending   = 1'b1;
        if (it.last_byte) n.final_seen = 1'b1;
        // An offer on an idle bus opens a transaction with the address byte.
        if (s.ph == PH_IDLE) begin
          n.err        = 1'b0;
          n.final_seen = it.last_byte;
          n.shreg      = dev_addr;
          n.shift_last = 1'b0;
          n.bits       = '0;
          n.sda        = 1'b1;
          n.ph         = PH_ST1;
          n.timer      = '0;
        end
      end
    end else if (s.ph == PH_WAIT) begin
      if (s.pending) n = load_byte(n);
    end else if (s.ph != PH_IDLE) begin
      if (t < need) begin
        n.timer = t[15:0];
      end else begin
        // The phase has run its ticks: take the next line change.
        n.timer = '0;
        case (s.ph)
          PH_ST1: begin
            n.scl = 1'b1;
            n.ph  = PH_ST2;
          end
          PH_ST2: begin
            n.sda = 1'b0;
            n.ph  = PH_ST3;
          end
          PH_ST3: begin
            n.bits = '0;
            n.scl  = 1'b0;
            n.sda  = s.shreg[7];
            n.ph   = PH_BLO;
          end
          PH_BLO: begin
            n.scl = 1'b1;
            n.ph  = PH_BHI;
          end
          PH_BHI: begin
            n.scl   = 1'b0;
            n.bits  = s.bits + 4'd1;
            n.shreg = {s.shreg[6:0], 1'b0};
            if (n.bits >= BITS_PER_BYTE) begin
              n.ph = PH_AKLO;
            end else begin
              n.sda = n.shreg[7];
              n.ph  = PH_BLO;
            end
          end
          PH_AKLO: begin
            n.scl = 1'b1;
            n.ph  = PH_AKHI;
          end
          PH_AKHI: begin
            // A high sample here is a not-acknowledge and aborts the transfer.
            n.scl = 1'b0;
            if (it.sda_sample) begin
              n.err     = 1'b1;
              n.pending = 1'b0;
              n.ph      = PH_SP1;
            end else if (s.shift_last) begin
              n.ph = PH_SP1;
            end else if (s.pending) begin
              n = load_byte(n);
            end else begin
              n.ph = PH_WAIT;
            end
          end
          PH_SP1: begin
            n.sda = 1'b0;
            n.ph  = PH_SP2;
          end
          PH_SP2: begin
            n.scl = 1'b1;
            n.ph  = PH_SP3;
          end
          PH_SP3: begin
            n.sda = 1'b1;
            n.ph  = PH_SP4;
          end
          PH_SP4: begin
            n.ph         = PH_IDLE;
            n.final_seen = 1'b0;
            n.shift_last = 1'b0;
            n.done       = 1'b1;
          end
          default: n.ph = PH_IDLE;
        endcase
      end
    end
    return n;
  endfunction

  // Queue an item for the driver and track the state it will leave behind.
  task automatic plan_item(in_item_t it);
    planned_bus = engine_step(planned_bus, planned_addr, planned_ticks, it);
    pending_items.push_back(it);
  endtask

  // Random items that mostly follow the protocol: bytes are offered when the
  // engine wants one, acknowledges are mostly low, a few offers are ignored.
  task automatic plan_random(int unsigned count);
    in_item_t    it;
    int unsigned made;
    logic        taken;
    made = 0;
    while (made < count) begin
      it = make_item(OP_TICK, 8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                     1'($urandom_range(0, 1)));
      taken = offer_ok(planned_bus);
      if (taken) begin
        if (planned_bus.ph == PH_IDLE) begin
          if ($urandom_range(0, 3) == 0) it.operation = OP_OFFER;
        end else if (planned_bus.ph == PH_WAIT) begin
          if ($urandom_range(0, 1) == 0) it.operation = OP_OFFER;
        end else if ($urandom_range(0, 19) == 0) begin
          it.operation = OP_OFFER;
        end
      end else if ($urandom_range(0, 29) == 0) begin
        it.operation = OP_OFFER;
      end
      if (it.operation == OP_TICK && planned_bus.ph == PH_AKHI)
        it.sda_sample = ($urandom_range(0, 99) < 6);
      if (it.operation == OP_TICK || taken) made++;
      plan_item(it);
    end
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_DEV_ADDR) planned_addr = val[7:0];
    else planned_ticks = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every planned item has been taken and answered.
  task automatic settle();
    while (pending_items.size() != 0 || in_valid || expected_bus.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Input driver: a new item only after the previous one was accepted.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_items.size() != 0 &&
          ((items_in >= CALM_FROM && items_in < CALM_TO) ||
           $urandom_range(0, 99) >= 7)) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a stretch without stalls.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_out >= HOLD_AT_RESULT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (results_out >= CALM_FROM && results_out < CALM_TO) ||
                   ($urandom_range(0, 99) >= 7);
    end
  end

  // Monitor: register writes, result checks and expectations for new items.
  always @(posedge clk) begin : bus_check
    out_item_t want;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEV_ADDR:    checked_addr  = cfg_data[7:0];
          CFG_PHASE_TICKS: checked_ticks = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_out++;
        if (expected_bus.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result item %0d arrived with nothing expected: %b", results_out,
                     out_data);
        end else begin
          want = expected_bus.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result item %0d: expected scl=%b sda=%b oe=%b want=%b busy=%b done=%b st=%b",
                       results_out, want.scl_level, want.sda_level,
                       want.sda_output_enable, want.byte_wanted, want.busy_res,
                       want.done_res, want.status);
              $display("result item %0d: actual   scl=%b sda=%b oe=%b want=%b busy=%b done=%b st=%b",
                       results_out, out_data.scl_level, out_data.sda_level,
                       out_data.sda_output_enable, out_data.byte_wanted,
                       out_data.busy_res, out_data.done_res, out_data.status);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        items_in++;
        checked_bus = engine_step(checked_bus, checked_addr, checked_ticks, in_data);
        want.scl_level         = checked_bus.scl;
        want.sda_level         = checked_bus.sda;
        want.sda_output_enable = !(checked_bus.ph == PH_AKLO || checked_bus.ph == PH_AKHI ||
                                   checked_bus.ph == PH_WAIT);
        want.byte_wanted       = offer_ok(checked_bus);
        want.busy_res          = checked_bus.ph != PH_IDLE;
        want.done_res          = checked_bus.done;
        want.status            = checked_bus.err;
        expected_bus.push_back(want);
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long.
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready) &&
        !(cfg_valid && cfg_ready)) begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // Stimulus sequence.
  initial begin
    checked_bus   = idle_bus();
    planned_bus   = idle_bus();
    checked_addr  = '0;
    planned_addr  = '0;
    checked_ticks = DEFAULT_PHASE_TICKS;
    planned_ticks = DEFAULT_PHASE_TICKS;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Idle ticks leave the bus untouched, whatever SDA reads.
    plan_item(make_item(OP_TICK, 8'h00, 1'b0, 1'b1));
    plan_item(make_item(OP_TICK, 8'hFF, 1'b1, 1'b0));
    settle();

    // Zero ticks per phase: open, offer while a byte is held, then a
    // not-acknowledge on the address byte that drops the held byte.
    write_reg(CFG_DEV_ADDR, 16'h00FF);
    write_reg(CFG_PHASE_TICKS, 16'h0000);
    plan_item(make_item(OP_OFFER, 8'h00, 1'b0, 1'b0));
    plan_item(make_item(OP_OFFER, 8'hFF, 1'b1, 1'b1));
    while (planned_bus.ph != PH_AKHI) plan_item(make_item(OP_TICK, 8'h00, 1'b0, 1'b0));
    plan_item(make_item(OP_TICK, 8'h00, 1'b0, 1'b1));
    while (planned_bus.ph != PH_IDLE) plan_item(make_item(OP_TICK, 8'hFF, 1'b1, 1'b1));
    settle();

    // Fastest timing, where the long receiver hold-off falls.
    write_reg(CFG_DEV_ADDR, 16'h00A6);
    write_reg(CFG_PHASE_TICKS, 16'h0001);
    plan_random(200);
    settle();

    // Slowest timing leaves a transaction hanging in its first phases.
    write_reg(CFG_DEV_ADDR, 16'h0000);
    write_reg(CFG_PHASE_TICKS, 16'hFFFF);
    if (planned_bus.ph == PH_IDLE) plan_item(make_item(OP_OFFER, 8'h5A, 1'b0, 1'b0));
    plan_random(60);
    settle();

    // Shorter timing takes effect in the middle of that transaction.
    write_reg(CFG_PHASE_TICKS, 16'h0002);
    write_reg(CFG_DEV_ADDR, 16'h003C);
    plan_random(150);
    settle();

    write_reg(CFG_PHASE_TICKS, DEFAULT_PHASE_TICKS);
    write_reg(CFG_DEV_ADDR, 16'($urandom_range(0, 255)));
    plan_random(100);
    settle();

    write_reg(CFG_PHASE_TICKS, 16'h0001);
    write_reg(CFG_DEV_ADDR, 16'h0055);
    plan_random(200);
    settle();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/i2cw_pkg.sv
hw/rtl/i2cw_front.sv
hw/rtl/i2cw_queue.sv
hw/rtl/i2cw_back.sv
hw/rtl/i2c_master_write_engine_core.sv
hw/rtl/i2cw_checker.sv
tb/tb_i2c_master_write_engine_core.sv
